// ===== hw/rtl/cca_pkg.sv =====
package cca_pkg;

    // row geometry
    localparam int ROW_BITS      = 64;
    localparam int MAX_ROW_WIDTH = 64;
    localparam int WIDTH_BITS    = 7;
    localparam int LIMIT_BITS    = 4;
    localparam int COUNT_BITS    = 4;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 7;

    // configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_BIRTH_LIMIT   = 2'd0,
        CFG_SURVIVE_LIMIT = 2'd1,
        CFG_ROW_WIDTH     = 2'd2,
        CFG_FORCE_BORDER  = 2'd3
    } t_cfg_idx;

    // reset values
    localparam logic [LIMIT_BITS-1:0] BIRTH_RESET   = 4'd5;
    localparam logic [LIMIT_BITS-1:0] SURVIVE_RESET = 4'd4;
    localparam logic [WIDTH_BITS-1:0] WIDTH_RESET   = 7'd64;

    // rule settings seen by the generation logic
    typedef struct packed {
        logic [LIMIT_BITS-1:0] birth_limit;
        logic [LIMIT_BITS-1:0] survive_limit;
        logic [WIDTH_BITS-1:0] eff_width;
        logic                  force_border;
    } t_cfg;

endpackage

// ===== hw/rtl/cca_in_if.sv =====
interface cca_in_if;

    logic                          valid;
    logic                          ready;
    logic [cca_pkg::ROW_BITS-1:0]  row_cells;
    logic                          final_row;

    modport source (output valid, output row_cells, output final_row, input ready);
    modport sink   (input valid, input row_cells, input final_row, output ready);

endinterface

// ===== hw/rtl/cca_out_if.sv =====
interface cca_out_if;

    logic                          valid;
    logic                          ready;
    logic [cca_pkg::ROW_BITS-1:0]  new_row_cells;
    logic                          map_done;

    modport source (output valid, output new_row_cells, output map_done, input ready);
    modport sink   (input valid, input new_row_cells, input map_done, output ready);

endinterface

// ===== hw/rtl/cca_cfg.sv =====
module cca_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [cca_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [cca_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    output cca_pkg::t_cfg                      o_cfg
);

    logic [cca_pkg::LIMIT_BITS-1:0] r_birth;
    logic [cca_pkg::LIMIT_BITS-1:0] r_survive;
    logic [cca_pkg::WIDTH_BITS-1:0] r_width;
    logic                           r_force;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_birth   <= cca_pkg::BIRTH_RESET;
            r_survive <= cca_pkg::SURVIVE_RESET;
            r_width   <= cca_pkg::WIDTH_RESET;
            r_force   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (cca_pkg::t_cfg_idx'(i_cfg_idx))
                cca_pkg::CFG_BIRTH_LIMIT:   r_birth   <= i_cfg_data[cca_pkg::LIMIT_BITS-1:0];
                cca_pkg::CFG_SURVIVE_LIMIT: r_survive <= i_cfg_data[cca_pkg::LIMIT_BITS-1:0];
                cca_pkg::CFG_ROW_WIDTH:     r_width   <= i_cfg_data[cca_pkg::WIDTH_BITS-1:0];
                cca_pkg::CFG_FORCE_BORDER:  r_force   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // clamp width into 1..max
    always_comb begin
        o_cfg.birth_limit   = r_birth;
        o_cfg.survive_limit = r_survive;
        o_cfg.force_border  = r_force;
        if (r_width > cca_pkg::WIDTH_BITS'(cca_pkg::MAX_ROW_WIDTH)) begin
            o_cfg.eff_width = cca_pkg::WIDTH_BITS'(cca_pkg::MAX_ROW_WIDTH);
        end else if (r_width == '0) begin
            o_cfg.eff_width = cca_pkg::WIDTH_BITS'(1);
        end else begin
            o_cfg.eff_width = r_width;
        end
    end

endmodule

// ===== hw/rtl/cca_gen.sv =====
module cca_gen (
    input  cca_pkg::t_cfg                  i_cfg,
    input  logic [cca_pkg::ROW_BITS-1:0]   i_up,
    input  logic [cca_pkg::ROW_BITS-1:0]   i_mid,
    input  logic [cca_pkg::ROW_BITS-1:0]   i_down,
    input  logic                           i_top,
    input  logic                           i_bottom,
    output logic [cca_pkg::ROW_BITS-1:0]   o_row
);

    logic [cca_pkg::ROW_BITS-1:0]   in_map;
    logic [cca_pkg::ROW_BITS+1:0]   p_up;
    logic [cca_pkg::ROW_BITS+1:0]   p_mid;
    logic [cca_pkg::ROW_BITS+1:0]   p_down;
    logic [cca_pkg::COUNT_BITS-1:0] cnt [cca_pkg::ROW_BITS];
    logic [cca_pkg::ROW_BITS-1:0]   live;
    logic [cca_pkg::ROW_BITS-1:0]   border;

    // cells in use, and rows padded with a live outside on both ends
    always_comb begin
        for (int i = 0; i < cca_pkg::ROW_BITS; i++) begin
            in_map[i] = (cca_pkg::WIDTH_BITS'(i) < i_cfg.eff_width);
        end
        p_up   = {1'b1, i_up   | ~in_map, 1'b1};
        p_mid  = {1'b1, i_mid  | ~in_map, 1'b1};
        p_down = {1'b1, i_down | ~in_map, 1'b1};
    end

    // per cell neighbour count and rule
    always_comb begin
        for (int x = 0; x < cca_pkg::ROW_BITS; x++) begin
            cnt[x] = cca_pkg::COUNT_BITS'(p_up[x]) + cca_pkg::COUNT_BITS'(p_up[x+1])
                   + cca_pkg::COUNT_BITS'(p_up[x+2]) + cca_pkg::COUNT_BITS'(p_mid[x])
                   + cca_pkg::COUNT_BITS'(p_mid[x+2]) + cca_pkg::COUNT_BITS'(p_down[x])
                   + cca_pkg::COUNT_BITS'(p_down[x+1]) + cca_pkg::COUNT_BITS'(p_down[x+2]);
            live[x] = p_mid[x+1] ? (cnt[x] >= i_cfg.survive_limit)
                                 : (cnt[x] > i_cfg.birth_limit);
            border[x] = (x == 0) || (cca_pkg::WIDTH_BITS'(x + 1) == i_cfg.eff_width)
                      || i_top || i_bottom;
            o_row[x] = in_map[x] & (live[x] | (i_cfg.force_border & border[x]));
        end
    end

endmodule

// ===== hw/rtl/cave_cellular_automaton_row.sv =====
// the result released by a row transfer is computed from the input register and the
// held rows and loaded into the result register, from which it transfers out
// throughput: one row per cycle while the result side is ready; the final row with a
// row pending yields two results and holds the input side until the second is loaded
// reset (synchronous, active low) clears the held-row state to an empty map and
// restores the rule registers to birth 5, survive 4, width 64, no forced border
module cave_cellular_automaton_row (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [cca_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [cca_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    cca_in_if.sink                             i_row,
    cca_out_if.source                          o_res
);

    cca_pkg::t_cfg                cfg;

    logic                         r_in_vld;
    logic [cca_pkg::ROW_BITS-1:0] r_in_row;
    logic                         r_in_fin;

    logic [cca_pkg::ROW_BITS-1:0] r_above;
    logic [cca_pkg::ROW_BITS-1:0] r_centre;
    logic                         r_held;
    logic                         r_top;
    logic                         r_second;

    logic                         r_out_vld;
    logic [cca_pkg::ROW_BITS-1:0] r_out_row;
    logic                         r_out_done;

    logic [cca_pkg::ROW_BITS-1:0] g_up;
    logic [cca_pkg::ROW_BITS-1:0] g_mid;
    logic [cca_pkg::ROW_BITS-1:0] g_down;
    logic                         g_top;
    logic                         g_bottom;
    logic [cca_pkg::ROW_BITS-1:0] g_row;

    logic                         emit;
    logic                         out_free;
    logic                         step_go;
    logic                         consume;

    cca_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // pick the three rows around the row being emitted
    always_comb begin
        if (!r_held) begin
            g_up     = '1;
            g_mid    = r_in_row;
            g_down   = '1;
            g_top    = 1'b1;
            g_bottom = 1'b1;
        end else if (!r_second) begin
            g_up     = r_above;
            g_mid    = r_centre;
            g_down   = r_in_row;
            g_top    = r_top;
            g_bottom = 1'b0;
        end else begin
            g_up     = r_above;
            g_mid    = r_centre;
            g_down   = '1;
            g_top    = 1'b0;
            g_bottom = 1'b1;
        end
    end

    cca_gen u_gen (
        .i_cfg    (cfg),
        .i_up     (g_up),
        .i_mid    (g_mid),
        .i_down   (g_down),
        .i_top    (g_top),
        .i_bottom (g_bottom),
        .o_row    (g_row)
    );

    // flow control
    assign emit     = r_in_vld & (r_held | r_in_fin);
    assign out_free = ~r_out_vld | o_res.ready;
    assign step_go  = r_in_vld & (~emit | out_free);
    assign consume  = step_go & ~(r_held & r_in_fin & ~r_second);
    assign i_row.ready = ~r_in_vld | consume;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_row.ready) begin
            r_in_vld <= i_row.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_row.ready && i_row.valid) begin
            r_in_row <= i_row.row_cells;
            r_in_fin <= i_row.final_row;
        end
    end

    // row buffers and map position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held   <= 1'b0;
            r_second <= 1'b0;
            r_top    <= 1'b1;
        end else if (step_go) begin
            if (!r_held) begin
                r_centre <= r_in_row;
                r_above  <= '1;
                r_top    <= 1'b1;
                r_held   <= ~r_in_fin;
            end else if (!r_second) begin
                r_above  <= r_centre;
                r_centre <= r_in_row;
                r_top    <= 1'b0;
                r_second <= r_in_fin;
            end else begin
                r_held   <= 1'b0;
                r_second <= 1'b0;
                r_top    <= 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= emit & step_go;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit && step_go) begin
            r_out_row  <= g_row;
            r_out_done <= r_in_fin & (~r_held | r_second);
        end
    end

    assign o_res.valid         = r_out_vld;
    assign o_res.new_row_cells = r_out_row;
    assign o_res.map_done      = r_out_done;

endmodule

// ===== sim/tb_cave_cellular_automaton_row.sv =====
module tb_cave_cellular_automaton_row;

    localparam int SETTLE_CYCLES = 4;
    localparam int QUIET_LIMIT   = 3000;
    localparam int HOLD_OFF      = 250;

    typedef struct packed {
        logic [cca_pkg::ROW_BITS-1:0] cells;
        logic                         done;
    } t_row_result;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n;
    logic                              i_cfg_we;
    logic [cca_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx;
    logic [cca_pkg::CFG_DATA_BITS-1:0] i_cfg_data;

    cca_in_if  row_if ();
    cca_out_if res_if ();

    cave_cellular_automaton_row i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_row      (row_if),
        .o_res      (res_if)
    );

    // rule registers as the block should hold them
    logic [cca_pkg::LIMIT_BITS-1:0] birth_lim   = cca_pkg::BIRTH_RESET;
    logic [cca_pkg::LIMIT_BITS-1:0] survive_lim = cca_pkg::SURVIVE_RESET;
    logic [cca_pkg::WIDTH_BITS-1:0] width_reg   = cca_pkg::WIDTH_RESET;
    logic                           border_on   = 1'b0;

    // row buffers of the map in progress
    logic [cca_pkg::ROW_BITS-1:0] above_row  = '1;
    logic [cca_pkg::ROW_BITS-1:0] centre_row = '0;
    logic                         row_pending = 1'b0;
    logic                         centre_top  = 1'b1;

    t_row_result expected_rows[$];
    int unsigned mismatches   = 0;
    int unsigned rows_sent    = 0;
    int unsigned row_gap_pct  = 0;
    int unsigned res_stall_pct = 0;
    int unsigned hold_left    = 0;

    // clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // cell of a row, anything outside the map is live
    function automatic logic [cca_pkg::COUNT_BITS-1:0] cell_at(
        logic [cca_pkg::ROW_BITS-1:0] r, int i, int w);
        if (i < 0 || i >= w) return cca_pkg::COUNT_BITS'(1);
        return {3'b000, r[i]};
    endfunction

    // one generation of the centre row
    function automatic logic [cca_pkg::ROW_BITS-1:0] next_generation(
        logic [cca_pkg::ROW_BITS-1:0] up,
        logic [cca_pkg::ROW_BITS-1:0] mid,
        logic [cca_pkg::ROW_BITS-1:0] down,
        logic top, logic bottom);
        int w;
        logic [cca_pkg::ROW_BITS-1:0] res;
        logic [cca_pkg::COUNT_BITS-1:0] cnt;
        logic live;
        if (width_reg > cca_pkg::MAX_ROW_WIDTH) w = cca_pkg::MAX_ROW_WIDTH;
        else if (width_reg == 0) w = 1;
        else w = int'(width_reg);
        res = '0;
        for (int x = 0; x < w; x++) begin
            cnt = '0;
            for (int d = -1; d <= 1; d++) begin
                cnt += cell_at(up, x + d, w) + cell_at(down, x + d, w);
                if (d != 0) cnt += cell_at(mid, x + d, w);
            end
            if (mid[x]) live = (cnt >= survive_lim);
            else live = (cnt > birth_lim);
            if (border_on && (x == 0 || x == w - 1 || top || bottom)) live = 1'b1;
            res[x] = live;
        end
        return res;
    endfunction

    task automatic forget_map();
        above_row   = '1;
        centre_row  = '0;
        row_pending = 1'b0;
        centre_top  = 1'b1;
    endtask

    task automatic push_result(logic [cca_pkg::ROW_BITS-1:0] cells, logic done);
        t_row_result r;
        r.cells = cells;
        r.done  = done;
        expected_rows.push_back(r);
    endtask

    // advance the map by one accepted row and queue what it releases
    task automatic predict_rows(logic [cca_pkg::ROW_BITS-1:0] cells, logic fin);
        if (!row_pending) begin
            centre_row = cells;
            above_row  = '1;
            centre_top = 1'b1;
            if (fin) begin
                push_result(next_generation('1, centre_row, '1, 1'b1, 1'b1), 1'b1);
                forget_map();
            end else begin
                row_pending = 1'b1;
            end
        end else begin
            push_result(next_generation(above_row, centre_row, cells, centre_top, 1'b0), 1'b0);
            above_row  = centre_row;
            centre_row = cells;
            centre_top = 1'b0;
            if (fin) begin
                push_result(next_generation(above_row, centre_row, '1, 1'b0, 1'b1), 1'b1);
                forget_map();
            end
        end
    endtask

    // offer one row, with random gaps, until it is taken
    task automatic send_row(logic [cca_pkg::ROW_BITS-1:0] cells, logic fin);
        while ($urandom_range(99) < row_gap_pct) begin
            row_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        row_if.valid     <= 1'b1;
        row_if.row_cells <= cells;
        row_if.final_row <= fin;
        @(posedge i_clk);
        while (!row_if.ready) @(posedge i_clk);
        predict_rows(cells, fin);
        rows_sent++;
    endtask

    // stop offering rows and wait for every pending result
    task automatic wait_idle();
        row_if.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_rows.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(cca_pkg::t_cfg_idx idx, logic [cca_pkg::CFG_DATA_BITS-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            cca_pkg::CFG_BIRTH_LIMIT:   birth_lim   = data[cca_pkg::LIMIT_BITS-1:0];
            cca_pkg::CFG_SURVIVE_LIMIT: survive_lim = data[cca_pkg::LIMIT_BITS-1:0];
            cca_pkg::CFG_ROW_WIDTH:     width_reg   = data[cca_pkg::WIDTH_BITS-1:0];
            cca_pkg::CFG_FORCE_BORDER:  border_on   = data[0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_rules(logic [cca_pkg::CFG_DATA_BITS-1:0] birth,
                             logic [cca_pkg::CFG_DATA_BITS-1:0] survive,
                             logic [cca_pkg::CFG_DATA_BITS-1:0] width,
                             logic [cca_pkg::CFG_DATA_BITS-1:0] border);
        wait_idle();
        write_reg(cca_pkg::CFG_BIRTH_LIMIT, birth);
        write_reg(cca_pkg::CFG_SURVIVE_LIMIT, survive);
        write_reg(cca_pkg::CFG_ROW_WIDTH, width);
        write_reg(cca_pkg::CFG_FORCE_BORDER, border);
    endtask

    function automatic logic [cca_pkg::ROW_BITS-1:0] random_row();
        logic [cca_pkg::ROW_BITS-1:0] a, b, c;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        c = {$urandom, $urandom};
        case ($urandom_range(6))
            0: return a & b;
            1: return a & b & c;
            2: return a | b;
            3: return a | b | c;
            4: return $urandom_range(1) ? '1 : '0;
            default: return a;
        endcase
    endfunction

    // rules weighted toward the interesting middle, with every value possible
    task automatic random_rules();
        logic [cca_pkg::LIMIT_BITS-1:0] b, s;
        logic [cca_pkg::WIDTH_BITS-1:0] w;
        b = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(6, 3));
        s = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(5, 2));
        case ($urandom_range(9))
            0: w = 7'd0;
            1: w = 7'd1;
            2: w = 7'($urandom_range(127, 65));
            3: w = 7'd64;
            default: w = 7'($urandom_range(64, 2));
        endcase
        set_rules({3'($urandom), b}, {3'($urandom), s}, w,
                  {6'($urandom), 1'($urandom_range(1))});
    endtask

    task automatic send_random_map();
        int len;
        len = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
        for (int r = 0; r < len; r++) send_row(random_row(), r == len - 1);
    endtask

    task automatic test_default_rules();
        send_row({$urandom, $urandom}, 1'b0);
        send_row({$urandom, $urandom}, 1'b0);
        send_row({$urandom, $urandom}, 1'b1);
    endtask

    task automatic test_single_row_maps();
        send_row('0, 1'b1);
        send_row('1, 1'b1);
    endtask

    // width zero acts as one, widths past the maximum clamp, bits past the width are outside
    task automatic test_width_extremes();
        set_rules(7'd5, 7'd4, 7'd0, 7'd0);
        send_row({$urandom, $urandom}, 1'b1);
        set_rules(7'd2, 7'd3, 7'd127, 7'd0);
        send_row({$urandom, $urandom}, 1'b0);
        send_row({$urandom, $urandom}, 1'b1);
        set_rules(7'd3, 7'd2, 7'd3, 7'd0);
        send_row(64'hFFFF_FFFF_FFFF_FFF8, 1'b0);
        send_row(64'hA5A5_A5A5_A5A5_A5A2, 1'b1);
    endtask

    task automatic test_limit_extremes();
        set_rules(7'd8, 7'd9, 7'd64, 7'd0);
        send_row('1, 1'b0);
        send_row({$urandom, $urandom}, 1'b1);
        set_rules(7'd15, 7'd0, 7'd64, 7'd0);
        send_row({$urandom, $urandom}, 1'b0);
        send_row({$urandom, $urandom}, 1'b1);
        set_rules(7'd0, 7'd15, 7'd64, 7'd0);
        send_row({$urandom, $urandom}, 1'b1);
    endtask

    task automatic test_forced_border();
        set_rules(7'd5, 7'd4, 7'd17, 7'd1);
        send_row('0, 1'b0);
        send_row('0, 1'b0);
        send_row('0, 1'b1);
    endtask

    // rules rewritten while a row is held, the next output uses the new ones
    task automatic test_rule_change_mid_map();
        set_rules(7'd5, 7'd4, 7'd64, 7'd0);
        send_row({$urandom, $urandom}, 1'b0);
        wait_idle();
        write_reg(cca_pkg::CFG_SURVIVE_LIMIT, 7'd2);
        write_reg(cca_pkg::CFG_FORCE_BORDER, 7'd1);
        send_row({$urandom, $urandom}, 1'b1);
    endtask

    // long result stall with rows still offered, then a full pause
    task automatic test_back_pressure();
        set_rules(7'd4, 7'd3, 7'd64, 7'd0);
        row_gap_pct   = 0;
        res_stall_pct = 0;
        hold_left     = HOLD_OFF;
        for (int r = 0; r < 30; r++) send_row(random_row(), r == 29);
        wait_idle();
    endtask

    task automatic test_random_maps(int unsigned gap_pct, int unsigned stall_pct,
                                    int unsigned count);
        int unsigned stop_at;
        stop_at       = rows_sent + count;
        row_gap_pct   = gap_pct;
        res_stall_pct = stall_pct;
        while (rows_sent < stop_at) begin
            if ($urandom_range(5) == 0) random_rules();
            send_random_map();
        end
    endtask

    // result side ready, random stalls and a counted hold-off
    initial begin
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= ($urandom_range(99) >= res_stall_pct);
            end
        end
    end

    task automatic note_mismatch(string field, logic [cca_pkg::ROW_BITS-1:0] want,
                                 logic [cca_pkg::ROW_BITS-1:0] got);
        mismatches++;
        if (mismatches <= 10) $display("mismatch %s: expected %h got %h", field, want, got);
    endtask

    // compare each result transfer with the oldest expected row
    initial begin
        t_row_result want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_if.valid && res_if.ready) begin
                if (expected_rows.size() == 0) begin
                    note_mismatch("unexpected row", '0, res_if.new_row_cells);
                end else begin
                    want = expected_rows.pop_front();
                    if (res_if.new_row_cells !== want.cells)
                        note_mismatch("new_row_cells", want.cells, res_if.new_row_cells);
                    if (res_if.map_done !== want.done)
                        note_mismatch("map_done", 64'(want.done), 64'(res_if.map_done));
                end
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((row_if.valid && row_if.ready) || (res_if.valid && res_if.ready)) quiet = 0;
            else quiet++;
        end
        $display("cave_cellular_automaton_row verification failed");
        $finish;
    end

    initial begin
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_idx        <= cca_pkg::CFG_BIRTH_LIMIT;
        i_cfg_data       <= '0;
        row_if.valid     <= 1'b0;
        row_if.row_cells <= '0;
        row_if.final_row <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_rules();
        test_single_row_maps();
        test_width_extremes();
        test_limit_extremes();
        test_forced_border();
        test_rule_change_mid_map();
        test_back_pressure();
        test_random_maps(8, 49, 520);
        test_random_maps(49, 8, 520);
        test_random_maps(0, 0, 520);

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && expected_rows.size() == 0) begin
            $display("cave_cellular_automaton_row verification clean");
        end else begin
            $display("cave_cellular_automaton_row verification failed");
        end
        $finish;
    end

endmodule

// ===== cave_cellular_automaton_row.f =====
hw/rtl/cca_pkg.sv
hw/rtl/cca_in_if.sv
hw/rtl/cca_out_if.sv
hw/rtl/cca_cfg.sv
hw/rtl/cca_gen.sv
hw/rtl/cave_cellular_automaton_row.sv
sim/tb_cave_cellular_automaton_row.sv
